>>> src/sorted_key_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key table
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SKT_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Implication checked in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

>>> src/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Operation and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package skt_pkg;
	localparam int unsigned DEFAULT_DEPTH = 16;
	localparam int unsigned DEFAULT_KEY_WIDTH = 32;
	localparam int unsigned DEFAULT_VALUE_WIDTH = 32;
	localparam int unsigned COUNT_WIDTH = 5;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_SEARCH = 3'd2,
		OP_FIRST  = 3'd3,
		OP_NEXT   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_READ,
		S_DONE
	} state_t;
endpackage

>>> src/skt_entry_ram.sv
// ----------------------------------------------------------------------------
// Entry memory
// One write port and one registered read port holding key and value.
// ----------------------------------------------------------------------------
module skt_entry_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// Sorted key table
// Up to DEPTH key/value entries in ascending key order, held in one memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              beat contents
//  input     in         in_valid / in_ready    op, key, value
//  result    out        out_valid / out_ready  status, key_out, value_out,
//                                              entry_count
//  config    in         cfg_we                 cfg_wdata (compare_signed)
//
// One beat is handled at a time through a single memory with one write port
// and one registered read port. A search, insert or remove scans the entries
// one a cycle up to the slot, then an insert or a remove shifts the entries
// above the slot one a cycle. A traverse passes through a read state, and
// an unknown operation goes straight to the done state. Reset clears the
// count, cursor and control; the memory is not cleared. A stalled result
// holds in the output registers, and the next beat is accepted from the
// cycle after the result has been taken.
module sorted_key_table_top
	import skt_pkg::*;
#(
	parameter int unsigned DEPTH       = DEFAULT_DEPTH,
	parameter int unsigned KEY_WIDTH   = DEFAULT_KEY_WIDTH,
	parameter int unsigned VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             op,
	input  logic [KEY_WIDTH-1:0]   key,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [KEY_WIDTH-1:0]   key_out,
	output logic [VALUE_WIDTH-1:0] value_out,
	output logic [COUNT_WIDTH-1:0] entry_count
);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned IW = AW + 1;
	localparam int unsigned EW = KEY_WIDTH + VALUE_WIDTH;
	// Flipping the top bit turns signed order into unsigned order.
	localparam logic [KEY_WIDTH-1:0] KEY_TOP = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

	state_t state_q, state_d;
	logic   sign_q;
	logic [IW-1:0] count_q, cursor_q, idx_q, slot_q;
	logic [2:0]             op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   hit_q;
	logic [EW-1:0]          hitent_q;   // entry found at the slot

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	skt_entry_ram #(.DEPTH(DEPTH), .WIDTH(EW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic                 accept;
	logic [IW-1:0]        start_idx;
	logic [KEY_WIDTH-1:0] rkey, flip;
	logic                 r_lt, r_eq;
	logic                 scan_end, ins_ok, rem_ok;
	logic                 res_load;
	status_t              res_status;
	logic [EW-1:0]        res_entry;

	assign in_ready = state_q == S_IDLE && !out_valid;
	assign accept = in_valid && in_ready;

	// Traverse next starts at the cursor; every other operation at entry 0.
	// The read for that entry is issued in the accepting cycle.
	assign start_idx = (op == 3'(OP_NEXT)) ? cursor_q : '0;

	// The entry read during the scan is compared in the selected order.
	assign rkey = rdata[EW-1 -: KEY_WIDTH];
	assign flip = sign_q ? KEY_TOP : '0;
	assign r_eq = rkey == key_q;
	assign r_lt = (rkey ^ flip) < (key_q ^ flip);

	// The scan stops at the first entry not below the key, or past the last.
	assign scan_end = idx_q >= count_q || !r_lt;
	assign ins_ok = op_q == 3'(OP_INSERT) && !hit_q && count_q < IW'(DEPTH);
	assign rem_ok = op_q == 3'(OP_REMOVE) && hit_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) begin
				if (op <= 3'(OP_SEARCH)) state_d = S_SCAN;
				else if (op == 3'(OP_FIRST) || op == 3'(OP_NEXT)) state_d = S_READ;
				else state_d = S_DONE;
			end
			S_SCAN: if (scan_end) state_d = S_DECIDE;
			S_DECIDE: begin
				if (ins_ok) state_d = S_SHIFT_UP;
				else if (rem_ok) state_d = S_SHIFT_DN;
				else state_d = S_DONE;
			end
			S_SHIFT_UP: if (idx_q == slot_q) state_d = S_DONE;
			S_SHIFT_DN: if (idx_q + IW'(1) >= count_q) state_d = S_DONE;
			S_READ: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port control and result loading.
	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		res_load = 1'b0;
		res_status = ST_NONE;
		res_entry = '0;
		unique case (state_q)
			S_IDLE: raddr = start_idx[AW-1:0];
			S_SCAN: raddr = AW'(idx_q + IW'(1));
			S_DECIDE: begin
				// Prime the first read of the shift that may follow.
				raddr = (op_q == 3'(OP_INSERT)) ? AW'(count_q - IW'(1))
					: AW'(slot_q + IW'(1));
				res_load = 1'b1;
				if (op_q == 3'(OP_INSERT)) begin
					if (hit_q) begin
						res_status = ST_DUP;
						res_entry = hitent_q;
					end else if (count_q >= IW'(DEPTH)) begin
						res_status = ST_FULL;
					end else begin
						res_status = ST_OK;
						res_entry = {key_q, val_q};
					end
				end else if (hit_q) begin
					res_status = ST_OK;
					res_entry = hitent_q;
				end
			end
			S_SHIFT_UP: begin
				// The entry below idx arrives this cycle and moves up one place;
				// at the slot the new entry is written instead.
				we = 1'b1;
				wdata = (idx_q == slot_q) ? {key_q, val_q} : rdata;
				raddr = AW'(idx_q - IW'(2));
			end
			S_SHIFT_DN: begin
				// The entry above idx arrives this cycle and moves down one place.
				we = idx_q + IW'(1) < count_q;
				raddr = AW'(idx_q + IW'(2));
			end
			S_READ: begin
				res_load = 1'b1;
				if (idx_q < count_q) begin
					res_status = ST_OK;
					res_entry = rdata;
				end
			end
			S_DONE: if (op_q > 3'(OP_NEXT)) res_load = 1'b1;
			default: ;
		endcase
	end

	// Control, count, cursor and the result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sign_q <= 1'b1;
			count_q <= '0;
			cursor_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) sign_q <= cfg_wdata;
			if (state_q == S_DONE) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			// The cursor follows its entry when the table shifts below it.
			unique case (state_q)
				S_SHIFT_UP: if (idx_q == slot_q) begin
					count_q <= count_q + IW'(1);
					if (slot_q < cursor_q) cursor_q <= cursor_q + IW'(1);
				end
				S_SHIFT_DN: if (idx_q + IW'(1) >= count_q) begin
					count_q <= count_q - IW'(1);
					if (slot_q < cursor_q) cursor_q <= cursor_q - IW'(1);
				end
				S_READ: if (idx_q < count_q) cursor_q <= idx_q + IW'(1);
				default: ;
			endcase
		end
	end

	// Operands, scan position and the result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				op_q <= op;
				key_q <= key;
				val_q <= value;
				idx_q <= start_idx;
			end
			S_SCAN: begin
				if (scan_end) begin
					slot_q <= idx_q;
					hit_q <= idx_q < count_q && r_eq;
					hitent_q <= rdata;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			S_DECIDE: idx_q <= (op_q == 3'(OP_INSERT)) ? count_q : slot_q;
			S_SHIFT_UP: if (idx_q != slot_q) idx_q <= idx_q - IW'(1);
			S_SHIFT_DN: if (idx_q + IW'(1) < count_q) idx_q <= idx_q + IW'(1);
			default: ;
		endcase
		if (res_load) begin
			status <= res_status;
			{key_out, value_out} <= res_entry;
		end
		if (state_q == S_DONE) entry_count <= COUNT_WIDTH'(count_q);
	end
endmodule

>>> src/skt_checker.sv
// ----------------------------------------------------------------------------
// Sorted key table checker
// Port-level checks on the result channel and entry count.
// ----------------------------------------------------------------------------
`include "sorted_key_table_top_macros.svh"
module skt_checker
	import skt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [4:0] entry_count
);
	`SKT_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status))
	`SKT_ASSERT(a_busy, clk, arst_n, out_valid, !in_ready)
	`SKT_ASSERT_NEXT(a_take, clk, arst_n, in_valid && in_ready, !in_ready)
	`SKT_ASSERT(a_count, clk, arst_n, out_valid, entry_count <= 5'(DEFAULT_DEPTH))
endmodule

bind sorted_key_table_top skt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.entry_count(entry_count)
);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives insert, remove, search and traverse beats with random idling on both
// channels, predicts every result from a local model of the table, and checks
// each result beat field by field in order. Both key orders are exercised.
// ----------------------------------------------------------------------------
module testbench;
	import skt_pkg::*;

	localparam int DEPTH = 16;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] key;
		logic [31:0] value;
	} table_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] key;
		logic [31:0] value;
		logic [4:0]  count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b1;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] op = '0;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [31:0] key_out;
	logic [31:0] value_out;
	logic [4:0] entry_count;

	sorted_key_table_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.key_out(key_out), .value_out(value_out), .entry_count(entry_count)
	);

	// Clock: period 8.
	always #4 clk = ~clk;

	// Local copy of the table, kept in step with the accepted command beats.
	logic [31:0] tbl_keys [DEPTH];
	logic [31:0] tbl_vals [DEPTH];
	int tbl_count = 0;
	int tbl_cursor = 0;
	logic key_signed = 1'b1;

	table_cmd_t pending_cmds[$];
	table_result_t awaited_results[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;   // when set, neither side idles
	bit stim_done = 1'b0;
	bit in_fire_q = 1'b0;   // a command beat was taken at the last rising edge

	// Maps a key to a number whose unsigned order is the active key order.
	function automatic logic [31:0] rank(logic [31:0] k);
		return key_signed ? (k ^ 32'h8000_0000) : k;
	endfunction

	// Applies one command to the local table and returns the result it causes.
	function automatic table_result_t apply_cmd(table_cmd_t c);
		table_result_t r;
		int slot;
		bit hit;
		r = '{status: ST_NONE, key: '0, value: '0, count: '0};
		if (c.op <= OP_SEARCH) begin
			slot = 0;
			while (slot < tbl_count && rank(tbl_keys[slot]) < rank(c.key))
				slot++;
			hit = slot < tbl_count && tbl_keys[slot] == c.key;
			if (c.op == OP_INSERT) begin
				if (hit) begin
					r.status = ST_DUP;
					r.key = tbl_keys[slot];
					r.value = tbl_vals[slot];
				end else if (tbl_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = tbl_count; i > slot; i--) begin
						tbl_keys[i] = tbl_keys[i-1];
						tbl_vals[i] = tbl_vals[i-1];
					end
					tbl_keys[slot] = c.key;
					tbl_vals[slot] = c.value;
					tbl_count++;
					if (slot < tbl_cursor)
						tbl_cursor++;
					r.status = ST_OK;
					r.key = c.key;
					r.value = c.value;
				end
			end else if (hit) begin
				r.status = ST_OK;
				r.key = tbl_keys[slot];
				r.value = tbl_vals[slot];
				if (c.op == OP_REMOVE) begin
					for (int i = slot; i + 1 < tbl_count; i++) begin
						tbl_keys[i] = tbl_keys[i+1];
						tbl_vals[i] = tbl_vals[i+1];
					end
					tbl_count--;
					if (slot < tbl_cursor)
						tbl_cursor--;
				end
			end
		end else if (c.op == OP_FIRST) begin
			if (tbl_count != 0) begin
				tbl_cursor = 1;
				r.status = ST_OK;
				r.key = tbl_keys[0];
				r.value = tbl_vals[0];
			end
		end else if (c.op == OP_NEXT) begin
			if (tbl_cursor < tbl_count) begin
				r.status = ST_OK;
				r.key = tbl_keys[tbl_cursor];
				r.value = tbl_vals[tbl_cursor];
				tbl_cursor++;
			end
		end
		r.count = tbl_count[4:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
		errors++;
	endtask

	// Driver: presents the next beat at the falling edge and holds it until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_fire_q) begin
				// beat still waiting; hold it
			end else if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 26)) begin
				in_valid <= 1'b1;
				op <= pending_cmds[0].op;
				key <= pending_cmds[0].key;
				value <= pending_cmds[0].value;
			end else begin
				in_valid <= 1'b0;
			end
			out_ready <= quiet || $urandom_range(99) >= 26;
		end
	end

	// Monitor: at the rising edge, accepted commands are predicted and
	// accepted results are checked against the oldest prediction.
	always @(posedge clk) begin
		table_result_t want;
		cycles <= cycles + 1;
		in_fire_q <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			awaited_results.push_back(apply_cmd(pending_cmds.pop_front()));
		end
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result beat", {30'd0, status}, 32'd0);
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", {30'd0, status}, {30'd0, want.status});
				if (key_out !== want.key)
					report_mismatch("key_out", key_out, want.key);
				if (value_out !== want.value)
					report_mismatch("value_out", value_out, want.value);
				if (entry_count !== want.count)
					report_mismatch("entry_count", {27'd0, entry_count}, {27'd0, want.count});
			end
		end
	end

	task automatic queue_cmd(logic [2:0] o, logic [31:0] k, logic [31:0] v);
		pending_cmds.push_back('{op: o, key: k, value: v});
	endtask

	// Waits for every queued command to be answered, then lets the block settle.
	task automatic drain();
		while (pending_cmds.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_order(logic s);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_we <= 1'b0;
		key_signed = s;
	endtask

	// Keys drawn from a small pool so that hits, duplicates and a full
	// table all happen often; now and then a fully random key.
	function automatic logic [31:0] pick_key();
		logic [31:0] pool [8] = '{32'h0, 32'h1, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff, 32'h0000_0040, 32'hc000_0000, 32'h4000_0000};
		case ($urandom_range(3))
			0: return $urandom();
			1: return pool[$urandom_range(7)];
			default: return $urandom_range(40) - 20;
		endcase
	endfunction

	task automatic random_phase(int n);
		int choice;
		for (int i = 0; i < n; i++) begin
			choice = $urandom_range(99);
			if (choice < 40)
				queue_cmd(OP_INSERT, pick_key(), $urandom());
			else if (choice < 58)
				queue_cmd(OP_REMOVE, pick_key(), $urandom());
			else if (choice < 72)
				queue_cmd(OP_SEARCH, pick_key(), $urandom());
			else if (choice < 78)
				queue_cmd(OP_FIRST, $urandom(), $urandom());
			else if (choice < 97)
				queue_cmd(OP_NEXT, $urandom(), $urandom());
			else
				queue_cmd(3'($urandom_range(7, 5)), $urandom(), $urandom());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty traversals, extremes of key and value, duplicates,
		// the cursor following inserts and removals, an unknown operation.
		queue_cmd(OP_NEXT, 32'h0, 32'h0);
		queue_cmd(OP_FIRST, 32'h0, 32'h0);
		queue_cmd(OP_SEARCH, 32'h5, 32'h0);
		queue_cmd(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
		queue_cmd(OP_INSERT, 32'h8000_0000, 32'h0);
		queue_cmd(OP_INSERT, 32'h0, 32'h1234_5678);
		queue_cmd(OP_INSERT, 32'h0, 32'h9999_9999);
		queue_cmd(OP_FIRST, 32'h0, 32'h0);
		queue_cmd(OP_NEXT, 32'h0, 32'h0);
		queue_cmd(OP_INSERT, 32'hffff_ffff, 32'h5555_aaaa);
		queue_cmd(OP_REMOVE, 32'h0, 32'h0);
		queue_cmd(OP_NEXT, 32'h0, 32'h0);
		queue_cmd(OP_NEXT, 32'h0, 32'h0);
		queue_cmd(OP_SEARCH, 32'h8000_0000, 32'h0);
		queue_cmd(OP_REMOVE, 32'h1, 32'h0);
		queue_cmd(3'd7, 32'hffff_ffff, 32'hffff_ffff);
		for (int i = 0; i < DEPTH; i++)
			queue_cmd(OP_INSERT, 32'(i * 3 + 100), 32'(i));
		queue_cmd(OP_INSERT, 32'h8000_0001, 32'h1);
		drain();

		// Random phases, each under one key order; the middle one runs
		// without idling so the block is seen at full rate.
		random_phase(230);
		drain();
		write_order(1'b0);
		quiet = 1'b1;
		random_phase(230);
		drain();
		quiet = 1'b0;
		write_order(1'b1);
		random_phase(240);
		drain();
		stim_done = 1'b1;
	end

	// End of run: verdict once all stimulus is answered, or on the limit.
	initial begin
		while (!stim_done && cycles < LIMIT)
			@(posedge clk);
		if (!stim_done) begin
			$display("== FAIL ==");
		end else if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
